// File: src/shell_line_segmenter_assert.svh
// ----------------------------------------------------------------------------
// shell_line_segmenter_assert.svh
// assertion macros shared by the segmenter rtl, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef SHELL_LINE_SEGMENTER_ASSERT_SVH
`define SHELL_LINE_SEGMENTER_ASSERT_SVH

// same-cycle implication
`define SLS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg
// types and character codes for the shell line segmenter
// ----------------------------------------------------------------------------
package sls_pkg;

    typedef enum logic [1:0] {
        CLS_WS      = 2'd0,
        CLS_COMMENT = 2'd1,
        CLS_OP      = 2'd2,
        CLS_WORD    = 2'd3
    } t_seg_class;

    // which byte may extend the current operator
    typedef enum logic [1:0] {
        OPX_NONE = 2'd0,
        OPX_PIPE = 2'd1,
        OPX_AMP  = 2'd2,
        OPX_GT   = 2'd3
    } t_op_ext;

    typedef struct packed {
        logic       line_open;
        t_seg_class cur_class;
        t_op_ext    op_ext;
        logic       sq_open;
        logic       dq_open;
        logic       bt_open;
        logic       esc_pending;
        logic       prev_dollar;
    } t_sls_flags;

    typedef struct packed {
        t_seg_class seg_class;
        logic       seg_lead;
        logic       last_of_line;
        logic       nest_overflow;
    } t_sls_result;

    localparam t_sls_flags FLAGS_RESET = '{
        line_open:   1'b0,
        cur_class:   CLS_WS,
        op_ext:      OPX_NONE,
        sq_open:     1'b0,
        dq_open:     1'b0,
        bt_open:     1'b0,
        esc_pending: 1'b0,
        prev_dollar: 1'b0
    };

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

// File: src/sls_step.sv
// ----------------------------------------------------------------------------
// sls_step
// one-character state update and result for the shell line segmenter
// ----------------------------------------------------------------------------
module sls_step
    import sls_pkg::*;
#(
    parameter int unsigned MAX_NEST = 15,
    localparam int unsigned DEPTH_W = $clog2(MAX_NEST + 1)
) (
    input  logic [7:0]         i_char,
    input  logic               i_last,
    input  t_sls_flags         i_flags,
    input  logic [DEPTH_W-1:0] i_depth,
    output t_sls_flags         o_flags,
    output logic [DEPTH_W-1:0] o_depth,
    output t_sls_result        o_result
);

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NEST);

    logic               is_blank;
    logic               is_op;
    logic               closed;
    logic               cont;
    logic               do_word;
    logic               had_dollar;
    logic               raise;
    logic               lower;
    logic               ovf;
    t_sls_flags         b_flags;
    logic [DEPTH_W-1:0] b_depth;

    always_comb begin
        is_blank = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
        is_op    = (i_char == CH_PIPE) || (i_char == CH_AMP) || (i_char == CH_SEMI) ||
                   (i_char == CH_LT) || (i_char == CH_GT);
        closed   = !i_flags.sq_open && !i_flags.dq_open && !i_flags.bt_open &&
                   (i_depth == '0) && !i_flags.esc_pending;

        cont = 1'b0;
        if (i_flags.line_open) begin
            case (i_flags.cur_class)
                CLS_WS:      cont = is_blank;
                CLS_COMMENT: cont = (i_char != CH_NL);
                CLS_OP: begin
                    cont = ((i_flags.op_ext == OPX_PIPE) && (i_char == CH_PIPE)) ||
                           ((i_flags.op_ext == OPX_AMP) &&
                            ((i_char == CH_AMP) || (i_char == CH_GT))) ||
                           ((i_flags.op_ext == OPX_GT) && (i_char == CH_GT));
                end
                CLS_WORD:    cont = !(closed && (is_blank || is_op || (i_char == CH_HASH)));
                default:     cont = 1'b0;
            endcase
        end

        // base state: current segment, or a freshly opened one
        b_flags = i_flags;
        b_depth = i_depth;
        do_word = 1'b0;
        if (cont) begin
            if (i_flags.cur_class == CLS_OP) begin
                b_flags.op_ext = OPX_NONE;
            end
            do_word = (i_flags.cur_class == CLS_WORD);
        end else begin
            b_flags           = FLAGS_RESET;
            b_flags.line_open = 1'b1;
            b_depth           = '0;
            if (is_blank) begin
                b_flags.cur_class = CLS_WS;
            end else if (i_char == CH_HASH) begin
                b_flags.cur_class = CLS_COMMENT;
            end else if (is_op) begin
                b_flags.cur_class = CLS_OP;
                if (i_char == CH_PIPE) begin
                    b_flags.op_ext = OPX_PIPE;
                end else if (i_char == CH_AMP) begin
                    b_flags.op_ext = OPX_AMP;
                end else if (i_char == CH_GT) begin
                    b_flags.op_ext = OPX_GT;
                end
            end else begin
                b_flags.cur_class = CLS_WORD;
                do_word           = 1'b1;
            end
        end

        // word byte: quotes, escapes, nesting
        o_flags    = b_flags;
        o_depth    = b_depth;
        had_dollar = b_flags.prev_dollar;
        raise      = 1'b0;
        lower      = 1'b0;
        ovf        = 1'b0;
        if (do_word) begin
            o_flags.prev_dollar = (i_char == CH_DOLLAR);
            if (b_flags.esc_pending) begin
                o_flags.esc_pending = 1'b0;
            end else if ((i_char == CH_BSLASH) && !b_flags.sq_open) begin
                o_flags.esc_pending = 1'b1;
            end else if ((i_char == CH_SQUOTE) && !b_flags.dq_open && !b_flags.bt_open) begin
                o_flags.sq_open = !b_flags.sq_open;
            end else if ((i_char == CH_DQUOTE) && !b_flags.sq_open && !b_flags.bt_open) begin
                o_flags.dq_open = !b_flags.dq_open;
            end else if ((i_char == CH_BTICK) && !b_flags.sq_open) begin
                o_flags.bt_open = !b_flags.bt_open;
            end else if (!b_flags.sq_open) begin
                if (i_char == CH_LPAREN) begin
                    raise = 1'b1;
                end else if ((i_char == CH_RPAREN) && (b_depth != '0)) begin
                    lower = 1'b1;
                end else if ((i_char == CH_LBRACE) && had_dollar) begin
                    raise = 1'b1;
                end else if ((i_char == CH_RBRACE) && (b_depth != '0)) begin
                    lower = 1'b1;
                end
            end
            if (lower) begin
                o_depth = b_depth - DEPTH_W'(1);
            end
            if (raise) begin
                if (b_depth >= DEPTH_MAX) begin
                    ovf = 1'b1;
                end else begin
                    o_depth = b_depth + DEPTH_W'(1);
                end
            end
        end

        o_result.seg_class     = o_flags.cur_class;
        o_result.seg_lead      = !cont;
        o_result.last_of_line  = i_last;
        o_result.nest_overflow = ovf;

        // end of line: everything back to reset
        if (i_last) begin
            o_flags = FLAGS_RESET;
            o_depth = '0;
        end
    end

endmodule

// File: src/shell_line_segmenter.sv
// ----------------------------------------------------------------------------
// shell_line_segmenter
// tags each byte of a shell command line with its segment class
// ----------------------------------------------------------------------------
// One byte of a command line comes in per transfer and one result goes out
// per transfer: the segment class (whitespace, comment, operator, word), a
// flag for the byte that opens a segment, an echo of the line end marker and
// a flag for a nesting raise past MAX_NEST. A byte is taken every cycle while
// the output side keeps up; a byte passes an input register and then a result
// register, and the segment state updates in the single step between them, so
// back-to-back bytes of one line follow at full rate. All segment state clears
// after the byte that carries the line end marker.
// ----------------------------------------------------------------------------
`include "shell_line_segmenter_assert.svh"

module shell_line_segmenter
    import sls_pkg::*;
#(
    parameter int unsigned MAX_NEST = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte stream in
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_line_end,
    // tagged stream out
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_seg_class,
    output logic       o_seg_lead,
    output logic       o_last_of_line,
    output logic       o_nest_overflow
);

    localparam int unsigned DEPTH_W = $clog2(MAX_NEST + 1);

    // input register
    logic               r_in_valid;
    logic [7:0]         r_in_char;
    logic               r_in_last;

    // segment state
    t_sls_flags         r_flags;
    logic [DEPTH_W-1:0] r_depth;
    t_sls_flags         n_flags;
    logic [DEPTH_W-1:0] n_depth;

    // result register
    logic               r_out_valid;
    t_sls_result        r_out;
    t_sls_result        n_out;

    logic               in_go;
    logic               adv;

    // byte moves into the result register when that slot is free or draining
    assign adv     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || adv;
    assign in_go   = i_valid && o_ready;

    sls_step #(
        .MAX_NEST (MAX_NEST)
    ) u_step (
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .i_flags  (r_flags),
        .i_depth  (r_depth),
        .o_flags  (n_flags),
        .o_depth  (n_depth),
        .o_result (n_out)
    );

    // control: valid bits and segment state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= FLAGS_RESET;
            r_depth     <= '0;
        end else begin
            if (in_go) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
                r_depth     <= n_depth;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_in_char <= i_char_byte;
            r_in_last <= i_line_end;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_seg_class     = r_out.seg_class;
    assign o_seg_lead      = r_out.seg_lead;
    assign o_last_of_line  = r_out.last_of_line;
    assign o_nest_overflow = r_out.nest_overflow;

    // overflow is only ever flagged on a word byte
    `SLS_ASSERT_IMPLY(a_ovf_in_word, r_out_valid && r_out.nest_overflow,
        r_out.seg_class == CLS_WORD, "nest overflow outside a word")
    // the byte that ends a line leaves the state cleared
    `SLS_ASSERT_NEXT(a_line_end_clears, adv && r_in_last,
        !r_flags.line_open && (r_depth == '0), "state not cleared after line end")
    // first byte of a line always opens a segment
    `SLS_ASSERT_NEXT(a_first_starts, adv && !r_flags.line_open,
        r_out.seg_lead, "first byte of line did not start a segment")
    // depth never passes its bound
    `SLS_ASSERT_IMPLY(a_depth_bound, 1'b1,
        r_depth <= DEPTH_W'(MAX_NEST), "nesting depth above bound")

endmodule
